// File: src/dqr_pkg.sv
// ============================================================================
// dqr_pkg: shared types and constants for the reversible deque
// Command and status codes, field widths and stream packing positions.
// ============================================================================
`default_nettype none

package dqr_pkg;

    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    // Result tdata layout, lowest bit first
    localparam int ST_LSB    = DATA_W;
    localparam int EMPTY_BIT = ST_LSB + STATUS_W;
    localparam int FILL_LSB  = EMPTY_BIT + 1;
    localparam int M_TDATA_W = FILL_LSB + FILL_W;

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REVERSE    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic [DATA_W-1:0] word_t;

endpackage

`default_nettype wire

// File: src/dqr_store.sv
// ============================================================================
// dqr_store: entry storage for the reversible deque
// One write port and one read port; read data is registered and holds
// between reads.
// ============================================================================
`default_nettype none

module dqr_store #(
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire dqr_pkg::word_t wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output dqr_pkg::word_t     rd_data
);

    dqr_pkg::word_t mem [DEPTH];
    dqr_pkg::word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: src/deque_with_reverse.sv
// ============================================================================
// deque_with_reverse: bounded double-ended queue of 32-bit words
// Ring buffer in a synchronous memory with a direction bit for reversal.
// ============================================================================
// Usage:
//   Requests arrive on the s_ stream: s_tuser carries the command (push back,
//   push front, pop front, reverse) and s_tdata the word to push. Every
//   request yields exactly one result on the m_ stream: m_tuser flags a popped
//   word, m_tdata carries the word (zero unless popped), the status, the
//   empty flag and the fill count after the request.
//   The result is registered: it is valid the cycle after acceptance.
//   Throughput is one request per cycle while the receiver takes each result.
//   Pointers update at the accepting edge, and the memory read for a pop
//   lands in the read register at that same edge, which also loads the result register.
//   Pop on an empty queue reports an error status; push on a full queue is
//   dropped and flagged. Reverse only flips the direction bit.
//   Reset empties the queue and clears the direction bit; memory contents are
//   left as they are. While the result register is held by a stalled
//   receiver, s_tready stays low and no request is taken.
// ============================================================================
`default_nettype none

module deque_with_reverse #(
    parameter int DEPTH = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [dqr_pkg::DATA_W-1:0]     s_tdata,  // value[31:0]
    input  wire logic [dqr_pkg::CMD_W-1:0]      s_tuser,  // command[1:0]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // popped_value[31:0], status[33:32], is_empty[34], fill_count[39:35]
    output logic [dqr_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tuser   // popped_valid
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_S   = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          rev_reg, rev_next;

    logic                         out_valid_reg;
    logic                         pv_reg, pv_next;
    logic [dqr_pkg::STATUS_W-1:0] st_reg, st_next;
    logic                         empty_reg;
    logic [dqr_pkg::FILL_W-1:0]   fill_reg;

    logic           accept;
    logic           is_push;
    logic           at_low;
    logic [AW-1:0]  head_dec, head_inc;
    logic [CW-1:0]  off_c;
    logic [AW:0]    slot_sum;
    logic [AW-1:0]  slot_far;
    logic           wr_en, rd_en;
    logic [AW-1:0]  wr_addr, rd_addr;
    dqr_pkg::word_t rd_data;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign is_push  = (s_tuser == dqr_pkg::CMD_PUSH_BACK) ||
                      (s_tuser == dqr_pkg::CMD_PUSH_FRONT);
    assign at_low   = (s_tuser == dqr_pkg::CMD_PUSH_FRONT) ? !rev_reg : rev_reg;

    assign head_dec = (head_reg == '0) ? LAST_SLOT : head_reg - AW'(1);
    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);

    // far end slot: head + count for a push, head + count - 1 for a pop
    assign off_c    = is_push ? count_reg : count_reg - CW'(1);
    assign slot_sum = {1'b0, head_reg} + {1'b0, off_c[AW-1:0]};
    assign slot_far = (slot_sum >= DEPTH_S) ? AW'(slot_sum - DEPTH_S)
                                             : slot_sum[AW-1:0];

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        pv_next    = 1'b0;
        st_next    = dqr_pkg::ST_OK;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        wr_addr    = slot_far;
        rd_addr    = slot_far;
        case (s_tuser)
            dqr_pkg::CMD_PUSH_BACK, dqr_pkg::CMD_PUSH_FRONT:
            begin
                if (count_reg >= DEPTH_C)
                begin
                    st_next = dqr_pkg::ST_FULL;
                end
                else
                begin
                    wr_en      = accept;
                    count_next = count_reg + CW'(1);
                    if (at_low)
                    begin
                        wr_addr   = head_dec;
                        head_next = head_dec;
                    end
                end
            end
            dqr_pkg::CMD_POP_FRONT:
            begin
                if (count_reg == '0)
                begin
                    st_next = dqr_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en      = accept;
                    pv_next    = 1'b1;
                    count_next = count_reg - CW'(1);
                    if (!rev_reg)
                    begin
                        rd_addr   = head_reg;
                        head_next = head_inc;
                    end
                end
            end
            dqr_pkg::CMD_REVERSE:
            begin
                rev_next = !rev_reg;
            end
            default:
            begin
                rev_next = rev_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                head_reg  <= head_next;
                count_reg <= count_next;
                rev_reg   <= rev_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload; hold while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pv_reg    <= pv_next;
            st_reg    <= st_next;
            empty_reg <= (count_next == '0);
            fill_reg  <= dqr_pkg::FILL_W'(count_next);
        end
    end

    dqr_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = pv_reg;
    assign m_tdata  = {fill_reg, empty_reg, st_reg, (pv_reg ? rd_data : '0)};

endmodule

`default_nettype wire

// File: src/dqr_chk.sv
// ============================================================================
// dqr_chk: port-level checker for the reversible deque
// Watches the result stream and the request handshake over time.
// ============================================================================
`default_nettype none

module dqr_chk (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [dqr_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic                           m_tuser
);

    logic [dqr_pkg::STATUS_W-1:0] st;
    logic                         empty;
    logic [dqr_pkg::FILL_W-1:0]   fill;

    assign st    = m_tdata[dqr_pkg::ST_LSB +: dqr_pkg::STATUS_W];
    assign empty = m_tdata[dqr_pkg::EMPTY_BIT];
    assign fill  = m_tdata[dqr_pkg::FILL_LSB +: dqr_pkg::FILL_W];

    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> st == dqr_pkg::ST_OK)
        else $error("popped word with error status");

    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> empty == (fill == '0))
        else $error("empty flag disagrees with fill count");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && st == dqr_pkg::ST_EMPTY |-> fill == '0 && !m_tuser)
        else $error("empty-pop error while entries held");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted request gave no result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind deque_with_reverse dqr_chk u_dqr_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
